// ----- rtl/tsc_pkg.sv -----
// Shared types, codes and helpers for the tar stream header checker.
// No dependencies; every other file uses this package.
`timescale 1ns / 1ps

package tsc_pkg;

	localparam int unsigned SIZE_W = 36;
	localparam int unsigned OFF_W  = 9;
	localparam int unsigned SUM_W  = 17;
	localparam int unsigned CKS_W  = 24;

	// byte_kind codes
	localparam logic [2:0] BK_HEADER   = 3'd0;
	localparam logic [2:0] BK_FILE     = 3'd1;
	localparam logic [2:0] BK_LONGNAME = 3'd2;
	localparam logic [2:0] BK_DIR      = 3'd3;
	localparam logic [2:0] BK_OTHER    = 3'd4;
	localparam logic [2:0] BK_PADDING  = 3'd5;
	localparam logic [2:0] BK_IGNORED  = 3'd6;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_END       = 3'd1;
	localparam logic [2:0] ST_CKS_BAD   = 3'd2;
	localparam logic [2:0] ST_SIZE_BAD  = 3'd3;
	localparam logic [2:0] ST_TOO_LARGE = 3'd4;
	localparam logic [2:0] ST_TRUNC     = 3'd5;
	localparam logic [2:0] ST_TOO_SMALL = 3'd6;

	// entry_kind codes
	localparam logic [1:0] EK_REGULAR  = 2'd0;
	localparam logic [1:0] EK_DIR      = 2'd1;
	localparam logic [1:0] EK_LONGNAME = 2'd2;
	localparam logic [1:0] EK_OTHER    = 2'd3;

	// header layout
	localparam logic [OFF_W-1:0] OFF_SIZE_FIRST = 9'd124;
	localparam logic [OFF_W-1:0] OFF_SIZE_END   = 9'd136;
	localparam logic [OFF_W-1:0] OFF_CKS_FIRST  = 9'd148;
	localparam logic [OFF_W-1:0] OFF_CKS_END    = 9'd156;
	localparam logic [OFF_W-1:0] OFF_TYPE       = 9'd156;
	localparam logic [OFF_W-1:0] OFF_LAST       = 9'd511;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_5     = 8'h35;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_L     = 8'h4C;

	localparam logic [SUM_W-1:0]  CKS_SPACE_SUM = 17'd32;
	localparam logic [SIZE_W-1:0] MAX_RESET     = 36'h2_0000_0000;

	typedef struct packed {
		logic seen;
		logic stop;
		logic bad;
	} oct_flags_t;

	typedef struct packed {
		logic [SIZE_W-1:0] val;
		oct_flags_t        flags;
	} oct_state_t;

	typedef struct packed {
		logic [7:0]        byte_out;
		logic [2:0]        byte_kind;
		logic              header_done;
		logic [1:0]        entry_kind;
		logic [SIZE_W-1:0] member_size;
		logic [2:0]        status;
	} result_t;

	// One character of an octal field: skip leading NUL/space, stop at a
	// trailing one, flag anything outside '0'..'7'.
	function automatic oct_state_t oct_feed(input logic [7:0] c, input oct_state_t s);
		oct_state_t r;
		r = s;
		if (!(s.flags.stop || s.flags.bad)) begin
			if (c == CH_NUL || c == CH_SPACE) begin
				if (s.flags.seen) begin
					r.flags.stop = 1'b1;
				end
			end else if (c < CH_0 || c > CH_7) begin
				r.flags.bad = 1'b1;
			end else begin
				r.flags.seen = 1'b1;
				r.val = {s.val[SIZE_W-4:0], c[2:0]};
			end
		end
		return r;
	endfunction

endpackage

// ----- rtl/tsc_if.sv -----
// Stream and configuration channel interfaces for the tar stream header checker.
// Depends on tsc_pkg.
`timescale 1ns / 1ps

interface tsc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tsc_out_if;
	logic                       valid;
	logic                       ready;
	logic [7:0]                 byte_out;
	logic [2:0]                 byte_kind;
	logic                       header_done;
	logic [1:0]                 entry_kind;
	logic [tsc_pkg::SIZE_W-1:0] member_size;
	logic [2:0]                 status;

	modport source (output valid, output byte_out, output byte_kind, output header_done,
		output entry_kind, output member_size, output status, input ready);
	modport sink (input valid, input byte_out, input byte_kind, input header_done,
		input entry_kind, input member_size, input status, output ready);
endinterface

interface tsc_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [tsc_pkg::SIZE_W-1:0] max_member_bytes;

	modport source (output valid, output max_member_bytes, input ready);
	modport sink (input valid, input max_member_bytes, output ready);
endinterface

// ----- rtl/tsc_core.sv -----
// Per-byte parser: header block sum and field parse, payload/padding tracking.
// Depends on tsc_pkg and tsc_if; result goes to tsc_out_buf.
`timescale 1ns / 1ps

module tsc_core (
	input  logic             clk,
	input  logic             arst_n,
	tsc_in_if.sink           in_ch,
	tsc_cfg_if.sink          cfg,
	input  logic             buf_ready,
	output logic             push,
	output tsc_pkg::result_t res
);
	import tsc_pkg::*;

	typedef enum logic [1:0] {PH_HEADER, PH_PAYLOAD, PH_PADDING, PH_DONE} phase_t;

	phase_t            phase_q, phase_d;
	logic [OFF_W-1:0]  off_q, off_d;
	logic              az_q, az_d;
	logic [SUM_W-1:0]  sum_q, sum_d;
	logic [CKS_W-1:0]  cks_q, cks_d;
	oct_flags_t        cks_fl_q, cks_fl_d;
	logic [SIZE_W-1:0] size_q, size_d;
	oct_flags_t        size_fl_q, size_fl_d;
	logic [1:0]        kind_q, kind_d;
	logic [SIZE_W-1:0] pay_q, pay_d;
	logic [OFF_W-1:0]  pad_q, pad_d;
	logic              full_q, full_d;
	logic [2:0]        sticky_q, sticky_d;
	logic [SIZE_W-1:0] max_q;

	// header values seen by this byte (cleared at the first byte of a block)
	logic              az_b;
	logic [SUM_W-1:0]  sum_b;
	logic [CKS_W-1:0]  cks_b;
	oct_flags_t        cks_fl_b;
	logic [SIZE_W-1:0] size_b;
	oct_flags_t        size_fl_b;
	logic [1:0]        kind_b;
	oct_state_t        oct_cks, oct_size;
	logic              in_cks, in_size, last;
	logic [7:0]        b;

	assign in_ch.ready = buf_ready;
	assign cfg.ready   = 1'b1;
	assign push        = in_ch.valid & buf_ready;
	assign b           = in_ch.data_byte;
	assign last        = in_ch.last_byte;

	assign in_cks  = (off_q >= OFF_CKS_FIRST) && (off_q < OFF_CKS_END);
	assign in_size = (off_q >= OFF_SIZE_FIRST) && (off_q < OFF_SIZE_END);

	always_comb begin
		phase_d   = phase_q;
		off_d     = off_q;
		az_d      = az_q;
		sum_d     = sum_q;
		cks_d     = cks_q;
		cks_fl_d  = cks_fl_q;
		size_d    = size_q;
		size_fl_d = size_fl_q;
		kind_d    = kind_q;
		pay_d     = pay_q;
		pad_d     = pad_q;
		full_d    = full_q;
		sticky_d  = sticky_q;

		res.byte_out    = b;
		res.byte_kind   = BK_IGNORED;
		res.header_done = 1'b0;
		res.entry_kind  = EK_REGULAR;
		res.member_size = '0;
		res.status      = ST_OK;

		if (off_q == '0) begin
			az_b      = 1'b1;
			sum_b     = '0;
			cks_b     = '0;
			cks_fl_b  = '0;
			size_b    = '0;
			size_fl_b = '0;
			kind_b    = EK_REGULAR;
		end else begin
			az_b      = az_q;
			sum_b     = sum_q;
			cks_b     = cks_q;
			cks_fl_b  = cks_fl_q;
			size_b    = size_q;
			size_fl_b = size_fl_q;
			kind_b    = kind_q;
		end
		oct_cks  = oct_feed(b, {{(SIZE_W-CKS_W){1'b0}}, cks_b, cks_fl_b});
		oct_size = oct_feed(b, {size_b, size_fl_b});

		case (phase_q)
			PH_HEADER: begin
				res.byte_kind = BK_HEADER;
				az_d  = az_b & (b == CH_NUL);
				sum_d = sum_b + (in_cks ? CKS_SPACE_SUM : {{(SUM_W-8){1'b0}}, b});
				if (in_cks) begin
					cks_d    = oct_cks.val[CKS_W-1:0];
					cks_fl_d = oct_cks.flags;
				end else begin
					cks_d    = cks_b;
					cks_fl_d = cks_fl_b;
				end
				if (in_size) begin
					size_d    = oct_size.val;
					size_fl_d = oct_size.flags;
				end else begin
					size_d    = size_b;
					size_fl_d = size_fl_b;
				end
				kind_d = kind_b;
				if (off_q == OFF_TYPE) begin
					if (b == CH_L) begin
						kind_d = EK_LONGNAME;
					end else if (b == CH_5) begin
						kind_d = EK_DIR;
					end else if (b == CH_0 || b == CH_NUL) begin
						kind_d = EK_REGULAR;
					end else begin
						kind_d = EK_OTHER;
					end
				end
				if (off_q == OFF_LAST) begin
					full_d = 1'b1;
					off_d  = '0;
					if (az_d) begin
						res.status = ST_END;
					end else if (cks_fl_d.bad ||
						({{(CKS_W-SUM_W){1'b0}}, sum_d} != cks_d)) begin
						res.status = ST_CKS_BAD;
					end else if (size_fl_d.bad) begin
						res.status = ST_SIZE_BAD;
					end else if (size_d > max_q) begin
						res.status = ST_TOO_LARGE;
					end else begin
						res.header_done = 1'b1;
						res.entry_kind  = kind_d;
						res.member_size = size_d;
						pay_d   = size_d;
						pad_d   = -size_d[OFF_W-1:0];
						phase_d = (size_d != '0) ? PH_PAYLOAD : PH_HEADER;
						if (last && size_d != '0) begin
							res.status = ST_TRUNC;
						end
					end
					if (res.status != ST_OK || last) begin
						phase_d  = PH_DONE;
						sticky_d = res.status;
					end
				end else begin
					off_d = off_q + 1'b1;
					if (last) begin
						res.status = full_q ? ST_OK : ST_TOO_SMALL;
						phase_d    = PH_DONE;
						sticky_d   = res.status;
					end
				end
			end
			PH_PAYLOAD: begin
				case (kind_q)
					EK_REGULAR:  res.byte_kind = BK_FILE;
					EK_DIR:      res.byte_kind = BK_DIR;
					EK_LONGNAME: res.byte_kind = BK_LONGNAME;
					default:     res.byte_kind = BK_OTHER;
				endcase
				pay_d = pay_q - 1'b1;
				if (pay_q == {{(SIZE_W-1){1'b0}}, 1'b1}) begin
					phase_d = (pad_q != '0) ? PH_PADDING : PH_HEADER;
				end
				if (last) begin
					res.status = (phase_d != PH_HEADER) ? ST_TRUNC : ST_OK;
					phase_d    = PH_DONE;
					sticky_d   = res.status;
				end
			end
			PH_PADDING: begin
				res.byte_kind = BK_PADDING;
				pad_d = pad_q - 1'b1;
				if (pad_q == {{(OFF_W-1){1'b0}}, 1'b1}) begin
					phase_d = PH_HEADER;
				end
				if (last) begin
					res.status = (phase_d != PH_HEADER) ? ST_TRUNC : ST_OK;
					phase_d    = PH_DONE;
					sticky_d   = res.status;
				end
			end
			default: begin
				res.status = sticky_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			off_q     <= '0;
			az_q      <= 1'b1;
			sum_q     <= '0;
			cks_q     <= '0;
			cks_fl_q  <= '0;
			size_q    <= '0;
			size_fl_q <= '0;
			kind_q    <= EK_REGULAR;
			pay_q     <= '0;
			pad_q     <= '0;
			full_q    <= 1'b0;
			sticky_q  <= ST_OK;
			max_q     <= MAX_RESET;
		end else begin
			if (cfg.valid) begin
				max_q <= cfg.max_member_bytes;
			end
			if (push) begin
				phase_q   <= phase_d;
				off_q     <= off_d;
				az_q      <= az_d;
				sum_q     <= sum_d;
				cks_q     <= cks_d;
				cks_fl_q  <= cks_fl_d;
				size_q    <= size_d;
				size_fl_q <= size_fl_d;
				kind_q    <= kind_d;
				pay_q     <= pay_d;
				pad_q     <= pad_d;
				full_q    <= full_d;
				sticky_q  <= sticky_d;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// block offset only advances inside header blocks
	a_off_zero_body: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD || phase_q == PH_PADDING) |-> off_q == '0)
		else $error("block offset nonzero outside header");
	a_pay_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> pay_q != '0)
		else $error("payload phase with nothing left");
	a_pad_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PADDING) |-> pad_q != '0)
		else $error("padding phase with nothing left");
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) |=> (phase_q == PH_DONE && $stable(sticky_q)))
		else $error("left done phase");
`endif

endmodule

// ----- rtl/tsc_out_buf.sv -----
// Two-entry output buffer (result register plus skid) for the result stream.
// Depends on tsc_pkg and tsc_if.
`timescale 1ns / 1ps

module tsc_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tsc_pkg::result_t res,
	output logic             buf_ready,
	tsc_out_if.source        out_ch
);
	import tsc_pkg::*;

	result_t main_q, skid_q;
	logic    main_vld_q, skid_vld_q;

	assign buf_ready = !skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_ch.ready || !main_vld_q) begin
			if (skid_vld_q) begin
				main_vld_q <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				main_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ch.ready || !main_vld_q) begin
			main_q <= skid_vld_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign out_ch.valid       = main_vld_q;
	assign out_ch.byte_out    = main_q.byte_out;
	assign out_ch.byte_kind   = main_q.byte_kind;
	assign out_ch.header_done = main_q.header_done;
	assign out_ch.entry_kind  = main_q.entry_kind;
	assign out_ch.member_size = main_q.member_size;
	assign out_ch.status      = main_q.status;

`ifndef NO_ASSERTIONS
	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> main_vld_q)
		else $error("skid entry without result entry");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> !push)
		else $error("transfer into full buffer");
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && out_ch.ready) |=> (main_vld_q && !skid_vld_q))
		else $error("skid entry not moved up");
`endif

endmodule

// ----- rtl/tar_stream_header_checker_top.sv -----
// Checks an uncompressed tar stream one byte per transfer. Each input byte
// yields exactly one result transfer: the byte, its kind (header, payload by
// entry type, padding, ignored), header_done with entry kind and size on the
// last byte of an accepted header, and a status. Throughput is one byte per
// clock while the skid entry is free: all per-byte work (running header sum,
// octal field parse, payload and padding counters) is combinational logic into
// the parser's state registers. Results leave through a two-entry output
// register, so the input keeps flowing while one result waits. Errors, the
// end marker and the end of stream are sticky until reset. max_member_bytes
// may be written on cfg at any time the stream is idle; cfg is always ready.
// Depends on tsc_pkg, tsc_if, tsc_core and tsc_out_buf.
`timescale 1ns / 1ps

module tar_stream_header_checker_top (
	input  logic      clk,
	input  logic      arst_n,
	tsc_in_if.sink    in_ch,
	tsc_out_if.source out_ch,
	tsc_cfg_if.sink   cfg
);
	import tsc_pkg::*;

	result_t res;
	logic    push;
	logic    buf_ready;

	tsc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg       (cfg),
		.buf_ready (buf_ready),
		.push      (push),
		.res       (res)
	);

	tsc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res       (res),
		.buf_ready (buf_ready),
		.out_ch    (out_ch)
	);

endmodule

// ----- dv/tb_tar_stream_header_checker_top.sv -----
// Self-checking bench for tar_stream_header_checker_top: streams tar members
// with random content and field formats, predicts every result transfer in a
// scoreboard class and compares it field by field. Uses tsc_pkg and tsc_if.
`timescale 1ns / 1ps

module tb_tar_stream_header_checker_top;
	import tsc_pkg::*;

	localparam int BLOCK = 512;

	typedef enum logic [1:0] {PH_HDR, PH_PAY, PH_PAD, PH_DONE} parse_phase_e;

	typedef enum int {HF_NONE, HF_ZERO, HF_CKS_VALUE, HF_CKS_CHAR, HF_SIZE_CHAR} header_fault_e;

	typedef enum int {
		END_MARKER, END_CKS, END_SIZE_FIELD, END_TOO_LARGE, END_CUT_HEADER,
		END_CUT_PAYLOAD, END_CUT_PADDING, END_AT_PAYLOAD, END_AT_PADDING,
		END_EMPTY_MEMBER, END_PARTIAL_BLOCK
	} stream_end_e;

	typedef struct packed {
		logic [SIZE_W-1:0] val;
		logic              seen;
		logic              stop;
		logic              bad;
	} octal_acc_t;

	class header_scoreboard;
		result_t           results_due[$];
		logic [SIZE_W-1:0] max_bytes;
		parse_phase_e      phase;
		logic [OFF_W-1:0]  offset;
		logic              all_zero;
		logic [SUM_W-1:0]  hsum;
		octal_acc_t        cks_acc;
		octal_acc_t        size_acc;
		logic [1:0]        kind;
		logic [SIZE_W-1:0] pay_left;
		logic [OFF_W-1:0]  pad_left;
		logic              full_seen;
		logic [2:0]        sticky;
		int                mismatches;
		int                checked;
		int                headers;

		function new();
			max_bytes = MAX_RESET;
			phase = PH_HDR;
			offset = '0;
			all_zero = 1'b1;
			hsum = '0;
			cks_acc = '0;
			size_acc = '0;
			kind = EK_REGULAR;
			pay_left = '0;
			pad_left = '0;
			full_seen = 1'b0;
			sticky = ST_OK;
			mismatches = 0;
			checked = 0;
			headers = 0;
		endfunction

		function void set_limit(logic [SIZE_W-1:0] v);
			max_bytes = v;
		endfunction

		function int outstanding();
			return results_due.size();
		endfunction

		local function octal_acc_t octal_step(logic [7:0] c, octal_acc_t a,
				logic [SIZE_W-1:0] keep);
			octal_acc_t r;
			r = a;
			if (!(a.stop || a.bad)) begin
				if (c == CH_NUL || c == CH_SPACE) begin
					if (a.seen)
						r.stop = 1'b1;
				end else if (c < CH_0 || c > CH_7) begin
					r.bad = 1'b1;
				end else begin
					r.seen = 1'b1;
					r.val = ((a.val << 3) | SIZE_W'(c - CH_0)) & keep;
				end
			end
			return r;
		endfunction

		// Works out the result transfer caused by one accepted byte.
		function void predict_byte(logic [7:0] d, logic last);
			result_t r;
			logic    in_cks;
			r = '0;
			r.byte_out = d;
			r.byte_kind = BK_IGNORED;
			r.status = ST_OK;
			case (phase)
				PH_HDR: begin
					if (offset == '0) begin
						all_zero = 1'b1;
						hsum = '0;
						cks_acc = '0;
						size_acc = '0;
						kind = EK_REGULAR;
					end
					r.byte_kind = BK_HEADER;
					in_cks = (offset >= OFF_CKS_FIRST) && (offset < OFF_CKS_END);
					if (d != CH_NUL)
						all_zero = 1'b0;
					hsum = hsum + (in_cks ? CKS_SPACE_SUM : SUM_W'(d));
					if (in_cks)
						cks_acc = octal_step(d, cks_acc, 36'hFF_FFFF);
					if (offset >= OFF_SIZE_FIRST && offset < OFF_SIZE_END)
						size_acc = octal_step(d, size_acc, '1);
					if (offset == OFF_TYPE) begin
						if (d == CH_L)
							kind = EK_LONGNAME;
						else if (d == CH_5)
							kind = EK_DIR;
						else if (d == CH_0 || d == CH_NUL)
							kind = EK_REGULAR;
						else
							kind = EK_OTHER;
					end
					if (offset == OFF_LAST) begin
						full_seen = 1'b1;
						offset = '0;
						if (all_zero) begin
							r.status = ST_END;
						end else if (cks_acc.bad || cks_acc.val != SIZE_W'(hsum)) begin
							r.status = ST_CKS_BAD;
						end else if (size_acc.bad) begin
							r.status = ST_SIZE_BAD;
						end else if (size_acc.val > max_bytes) begin
							r.status = ST_TOO_LARGE;
						end else begin
							r.header_done = 1'b1;
							r.entry_kind = kind;
							r.member_size = size_acc.val;
							pay_left = size_acc.val;
							pad_left = 9'd0 - size_acc.val[OFF_W-1:0];
							phase = (size_acc.val != '0) ? PH_PAY : PH_HDR;
							if (last && size_acc.val != '0)
								r.status = ST_TRUNC;
							headers++;
						end
						if (r.status != ST_OK || last) begin
							phase = PH_DONE;
							sticky = r.status;
						end
					end else begin
						offset = offset + 1'b1;
						if (last) begin
							// a partial block is only an error if nothing came before it
							r.status = full_seen ? ST_OK : ST_TOO_SMALL;
							phase = PH_DONE;
							sticky = r.status;
						end
					end
				end
				PH_PAY, PH_PAD: begin
					if (phase == PH_PAY) begin
						case (kind)
							EK_REGULAR:  r.byte_kind = BK_FILE;
							EK_DIR:      r.byte_kind = BK_DIR;
							EK_LONGNAME: r.byte_kind = BK_LONGNAME;
							default:     r.byte_kind = BK_OTHER;
						endcase
						pay_left = pay_left - 1'b1;
						if (pay_left == '0)
							phase = (pad_left != '0) ? PH_PAD : PH_HDR;
					end else begin
						r.byte_kind = BK_PADDING;
						pad_left = pad_left - 1'b1;
						if (pad_left == '0)
							phase = PH_HDR;
					end
					if (last) begin
						r.status = (phase != PH_HDR) ? ST_TRUNC : ST_OK;
						phase = PH_DONE;
						sticky = r.status;
					end
				end
				default: begin
					r.status = sticky;
				end
			endcase
			results_due = {results_due, r};
		endfunction

		local function void report(string field, logic [SIZE_W-1:0] e, logic [SIZE_W-1:0] g);
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, e, g);
			mismatches++;
		endfunction

		function void check_result(result_t got);
			result_t e;
			if (results_due.size() == 0) begin
				$display("%0t: result transfer with none due, byte_out %0h", $time,
					got.byte_out);
				mismatches++;
				return;
			end
			e = results_due.pop_front();
			checked++;
			if (got.byte_out !== e.byte_out)
				report("byte_out", e.byte_out, got.byte_out);
			if (got.byte_kind !== e.byte_kind)
				report("byte_kind", e.byte_kind, got.byte_kind);
			if (got.header_done !== e.header_done)
				report("header_done", e.header_done, got.header_done);
			if (got.entry_kind !== e.entry_kind)
				report("entry_kind", e.entry_kind, got.entry_kind);
			if (got.member_size !== e.member_size)
				report("member_size", e.member_size, got.member_size);
			if (got.status !== e.status)
				report("status", e.status, got.status);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	tsc_in_if  in_ch();
	tsc_out_if out_ch();
	tsc_cfg_if cfg();

	tar_stream_header_checker_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	header_scoreboard  sb = new();
	logic [7:0]        hdr [0:BLOCK-1];
	logic [SIZE_W-1:0] max_bytes_now;
	bit                steady;
	int                limit_writes;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("Verification failed");
		$finish;
	end

	// One place sees every transfer, so prediction always precedes its check.
	always @(posedge clk) begin : watch
		result_t got;
		if (arst_n) begin
			if (cfg.valid && cfg.ready)
				sb.set_limit(cfg.max_member_bytes);
			if (in_ch.valid && in_ch.ready)
				sb.predict_byte(in_ch.data_byte, in_ch.last_byte);
			if (out_ch.valid && out_ch.ready) begin
				got.byte_out = out_ch.byte_out;
				got.byte_kind = out_ch.byte_kind;
				got.header_done = out_ch.header_done;
				got.entry_kind = out_ch.entry_kind;
				got.member_size = out_ch.member_size;
				got.status = out_ch.status;
				sb.check_result(got);
			end
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		if (r < 99)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	initial begin : sink_side
		int n;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			n = steady ? 0 : idle_len();
			if (n > 0) begin
				out_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	task automatic send_byte(logic [7:0] d, logic last);
		int gap;
		gap = steady ? 0 : idle_len();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= d;
		in_ch.last_byte <= last;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Drop valid and wait until every result due has been checked.
	task automatic quiesce();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	task automatic write_limit(logic [SIZE_W-1:0] v);
		cfg.valid <= 1'b1;
		cfg.max_member_bytes <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		max_bytes_now = v;
		limit_writes++;
	endtask

	function automatic logic [7:0] pad_char();
		return $urandom_range(0, 1) ? CH_SPACE : CH_NUL;
	endfunction

	function automatic logic [7:0] bad_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while (c == CH_NUL || c == CH_SPACE || (c >= CH_0 && c <= CH_7));
		return c;
	endfunction

	// Octal text with random blank lead-in, optional leading zeros, a blank
	// terminator and junk past it. spoil puts a bad char where it is parsed.
	task automatic put_octal(int start, int len, logic [SIZE_W-1:0] value, bit spoil);
		int                ndig;
		int                nmin;
		int                lead;
		int                i;
		logic [SIZE_W-1:0] v;
		v = value;
		nmin = 0;
		while (v != '0) begin
			nmin++;
			v = v >> 3;
		end
		if (nmin == 0 && (spoil || $urandom_range(0, 1)))
			nmin = 1;
		ndig = nmin + $urandom_range(0, len - nmin);
		lead = (ndig == 0) ? len : $urandom_range(0, len - ndig);
		for (i = 0; i < lead; i++)
			hdr[start + i] = pad_char();
		for (i = 0; i < ndig; i++)
			hdr[start + lead + i] = CH_0 + 8'((value >> (3 * (ndig - 1 - i))) & 36'h7);
		if (lead + ndig < len) begin
			hdr[start + lead + ndig] = pad_char();
			for (i = lead + ndig + 1; i < len; i++)
				hdr[start + i] = 8'($urandom_range(0, 255));
		end
		if (spoil)
			hdr[start + $urandom_range(0, lead + ndig - 1)] = bad_char();
	endtask

	task automatic build_header(logic [SIZE_W-1:0] size, logic [7:0] type_byte,
			header_fault_e fault);
		logic [SUM_W-1:0] s;
		int               i;
		for (i = 0; i < BLOCK; i++)
			hdr[i] = (fault == HF_ZERO) ? CH_NUL : 8'($urandom_range(0, 255));
		if (fault != HF_ZERO) begin
			put_octal(int'(OFF_SIZE_FIRST), int'(OFF_SIZE_END - OFF_SIZE_FIRST), size,
				fault == HF_SIZE_CHAR);
			hdr[OFF_TYPE] = type_byte;
			s = '0;
			for (i = 0; i < BLOCK; i++)
				s = s + ((i >= OFF_CKS_FIRST && i < OFF_CKS_END) ? CKS_SPACE_SUM : SUM_W'(hdr[i]));
			case (fault)
				HF_CKS_VALUE: put_octal(int'(OFF_CKS_FIRST), 8,
					SIZE_W'(s) + SIZE_W'($urandom_range(1, 999)), 1'b0);
				HF_CKS_CHAR:  put_octal(int'(OFF_CKS_FIRST), 8, SIZE_W'(s), 1'b1);
				default:      put_octal(int'(OFF_CKS_FIRST), 8, SIZE_W'(s), 1'b0);
			endcase
		end
	endtask

	// Header, payload and padding; last_byte goes on byte stop_at, which also
	// ends the member there.
	task automatic send_member(logic [SIZE_W-1:0] size, logic [7:0] type_byte,
			header_fault_e fault, longint stop_at);
		longint body;
		longint i;
		build_header(size, type_byte, fault);
		body = 0;
		if (fault == HF_NONE && size <= max_bytes_now)
			body = longint'(size) + (BLOCK - longint'(size) % BLOCK) % BLOCK;
		for (i = 0; i < BLOCK + body; i++) begin
			send_byte((i < BLOCK) ? hdr[int'(i)] : 8'($urandom_range(0, 255)), i == stop_at);
			if (i == stop_at)
				break;
		end
	endtask

	function automatic logic [7:0] pick_type();
		logic [7:0] c;
		case ($urandom_range(0, 4))
			0: return CH_0;
			1: return CH_NUL;
			2: return CH_5;
			3: return CH_L;
			default: begin
				do c = 8'($urandom_range(0, 255));
				while (c == CH_0 || c == CH_NUL || c == CH_5 || c == CH_L);
				return c;
			end
		endcase
	endfunction

	// One way of closing the stream, then bytes that must come back ignored.
	task automatic close_stream();
		stream_end_e how;
		int          sz;
		int          pad;
		how = stream_end_e'($urandom_range(0, 10));
		sz = $urandom_range(2, 700);
		case (how)
			END_MARKER:
				send_member('0, CH_NUL, HF_ZERO, $urandom_range(0, 1) ? BLOCK - 1 : -1);
			END_CKS:
				send_member(SIZE_W'(sz), pick_type(),
					$urandom_range(0, 1) ? HF_CKS_VALUE : HF_CKS_CHAR, -1);
			END_SIZE_FIELD:
				send_member(SIZE_W'(sz), pick_type(), HF_SIZE_CHAR,
					$urandom_range(0, 1) ? BLOCK - 1 : -1);
			END_TOO_LARGE:
				send_member($urandom_range(0, 1) ? max_bytes_now + 1'b1 : '1, pick_type(),
					HF_NONE, -1);
			END_CUT_HEADER:
				send_member(SIZE_W'(sz), pick_type(), HF_NONE, BLOCK - 1);
			END_CUT_PAYLOAD:
				send_member(SIZE_W'(sz), pick_type(), HF_NONE, BLOCK + $urandom_range(0, sz - 2));
			END_CUT_PADDING: begin
				sz = $urandom_range(1, 510);
				pad = BLOCK - sz;
				send_member(SIZE_W'(sz), pick_type(), HF_NONE,
					BLOCK + sz + $urandom_range(0, pad - 2));
			end
			END_AT_PAYLOAD: begin
				if ($urandom_range(0, 1))
					sz = BLOCK * $urandom_range(1, 2);
				send_member(SIZE_W'(sz), pick_type(), HF_NONE, BLOCK + sz - 1);
			end
			END_AT_PADDING: begin
				sz = $urandom_range(1, 511);
				send_member(SIZE_W'(sz), pick_type(), HF_NONE, 2 * BLOCK - 1);
			end
			END_EMPTY_MEMBER:
				send_member('0, pick_type(), HF_NONE, BLOCK - 1);
			default:
				send_member(SIZE_W'(sz), pick_type(), HF_NONE, $urandom_range(0, BLOCK - 2));
		endcase
		repeat ($urandom_range(40, 200))
			send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.last_byte = 1'b0;
		cfg.valid = 1'b0;
		cfg.max_member_bytes = '0;
		max_bytes_now = MAX_RESET;
		steady = 1'b1;
		limit_writes = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero-size member right at a zero limit, sent back to back
		write_limit('0);
		send_member('0, pick_type(), HF_NONE, -1);
		quiesce();
		write_limit(SIZE_W'($urandom_range(1024, 4096)));
		steady = 1'b0;
		close_stream();
		quiesce();
		repeat (4) @(posedge clk);

		$display("Run summary: %0d result transfers checked, %0d headers accepted",
			sb.checked, sb.headers);
		$display("Size limit written %0d times; stream closed with status %0d",
			limit_writes, sb.sticky);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
